// ===== rtl/cfe_pkg.sv =====
// shared types and constants for the continued fraction expander
package cfe_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH        = 32;
   localparam int LIMIT_WIDTH        = 7;

   localparam logic [LIMIT_WIDTH-1:0] TERM_CAP    = 7'd64;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT,
      ST_FAULT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic advance;
      logic show_fault;
   } cmd_type;

   typedef struct packed {
      logic divisor_zero;
      logic step_last;
      logic term_last;
   } status_type;

endpackage

// ===== rtl/continued_fraction_expander_unit.sv =====
// Continued fraction expander: takes a num/den pair and returns one word per partial
// quotient by exact Euclidean division, the last word flagged. Each term is computed by a
// restoring shift-subtract divider that resolves one quotient bit per cycle, then the word
// for that term is handed over. A zero denominator gives a single error word instead.
// Items are processed one at a time: req_ready is high only while no expansion is in
// progress. The term limit register (csr_data, reset 64; 0 acts as 1, above 64 acts as
// 64) is writable only while the block is idle: csr_ready follows req_ready.
module continued_fraction_expander_unit import cfe_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LIMIT_WIDTH-1:0] csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FIELD_WIDTH-1:0] req_num_value,
   input  logic [FIELD_WIDTH-1:0] req_den_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_WIDTH-1:0] rsp_term,
   output logic                   rsp_last,
   output logic                   rsp_cut_short,
   output logic                   rsp_div_error
);

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   assign csr_ready = req_ready;
   assign csr_write = csr_valid && csr_ready;

   cfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfe_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_write),
      .csr_data      (csr_data),
      .req_num_value (req_num_value),
      .req_den_value (req_den_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_term      (rsp_term),
      .rsp_last      (rsp_last),
      .rsp_cut_short (rsp_cut_short),
      .rsp_div_error (rsp_div_error)
   );

endmodule

// ===== rtl/cfe_datapath.sv =====
// euclidean datapath: shift-subtract divider, term counter and limit register
module cfe_datapath import cfe_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [LIMIT_WIDTH-1:0] csr_data,
   input  logic [FIELD_WIDTH-1:0] req_num_value,
   input  logic [FIELD_WIDTH-1:0] req_den_value,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [FIELD_WIDTH-1:0] rsp_term,
   output logic                   rsp_last,
   output logic                   rsp_cut_short,
   output logic                   rsp_div_error
);

   localparam int StepWidth = $clog2(DATA_WIDTH);

   logic [LIMIT_WIDTH-1:0] max_terms_ff;
   logic [DATA_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DATA_WIDTH:0]    rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]  quo_ff, quo_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic [LIMIT_WIDTH-1:0] count_ff, count_in;

   logic [DATA_WIDTH:0]    rem_shift;
   logic [DATA_WIDTH:0]    rem_diff;
   logic                   fits;
   logic [LIMIT_WIDTH-1:0] limit;
   logic [LIMIT_WIDTH-1:0] count_next;
   logic                   rem_zero;
   logic                   hit_limit;

   assign rem_shift  = {rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
   assign fits       = rem_shift >= {1'b0, divisor_ff};
   assign rem_diff   = rem_shift - {1'b0, divisor_ff};
   assign count_next = count_ff + LIMIT_WIDTH'(1);
   assign rem_zero   = rem_ff == '0;
   assign hit_limit  = count_next >= limit;

   always_comb begin
      if (max_terms_ff == '0) begin
         limit = LIMIT_WIDTH'(1);
      end else if (max_terms_ff > TERM_CAP) begin
         limit = TERM_CAP;
      end else begin
         limit = max_terms_ff;
      end
   end

   assign status.divisor_zero = divisor_ff == '0;
   assign status.step_last    = step_ff == StepWidth'(DATA_WIDTH - 1);
   assign status.term_last    = rem_zero || hit_limit;

   assign rsp_term      = cmd.show_fault ? '0 : FIELD_WIDTH'(quo_ff);
   assign rsp_last      = cmd.show_fault || rem_zero || hit_limit;
   assign rsp_cut_short = !cmd.show_fault && !rem_zero && hit_limit;
   assign rsp_div_error = cmd.show_fault;

   always_comb begin
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         divisor_in = DATA_WIDTH'(req_den_value);
         quo_in     = DATA_WIDTH'(req_num_value);
         rem_in     = '0;
         step_in    = '0;
         count_in   = '0;
      end else if (cmd.step) begin
         quo_in  = {quo_ff[DATA_WIDTH-2:0], fits};
         rem_in  = fits ? rem_diff : rem_shift;
         step_in = step_ff + StepWidth'(1);
      end else if (cmd.advance) begin
         quo_in     = divisor_ff;
         divisor_in = rem_ff[DATA_WIDTH-1:0];
         rem_in     = '0;
         step_in    = '0;
         count_in   = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_terms_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         max_terms_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= '0;
         rem_ff     <= '0;
         quo_ff     <= '0;
         step_ff    <= '0;
         count_ff   <= '0;
      end else begin
         divisor_ff <= divisor_in;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         step_ff    <= step_in;
         count_ff   <= count_in;
      end
   end

`ifndef SYNTH
   a_step_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.divisor_zero)
      else $error("divider stepped with zero divisor");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.step_last |=> rem_ff < {1'b0, divisor_ff})
      else $error("remainder not below divisor after division");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> count_next < limit)
      else $error("advanced past the term limit");
`endif

endmodule

// ===== rtl/cfe_ctrl.sv =====
// sequencing state machine for load, division, term emission and error word
module cfe_ctrl import cfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.divisor_zero ? ST_FAULT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.term_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_DIVIDE;
               end
            end
         end
         ST_FAULT: begin
            rsp_valid      = 1'b1;
            cmd.show_fault = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a word is pending");

   a_check_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(req_valid && req_ready))
      else $error("check state entered without an accepted item");

   a_idle_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (cmd.show_fault || status.term_last) |=> req_ready)
      else $error("not idle after final word");
`endif

endmodule
